### sv/tppd_pkg.sv
// Shared types and constants for the timing pulse peak detector.
// No dependencies; imported by tppd_tracker and the top level.
package tppd_pkg;

  localparam int unsigned PosW  = 32;
  localparam int unsigned SampW = 16;
  localparam int unsigned RunW  = 8;
  localparam int unsigned IntW  = 16;
  localparam int unsigned RegIdxW = 2;

  // Register indexes on the configuration port
  localparam logic [RegIdxW-1:0] REG_MIN_RISING_RUN     = 2'd0;
  localparam logic [RegIdxW-1:0] REG_NOMINAL_INTERVAL   = 2'd1;
  localparam logic [RegIdxW-1:0] REG_INTERVAL_TOLERANCE = 2'd2;

  // Register values after reset
  localparam logic [RunW-1:0] RST_MIN_RISING_RUN     = 8'd10;
  localparam logic [IntW-1:0] RST_NOMINAL_INTERVAL   = 16'd4800;
  localparam logic [IntW-1:0] RST_INTERVAL_TOLERANCE = 16'd10;

  localparam logic [RunW-1:0] RUN_MAX = {RunW{1'b1}};
  localparam logic [IntW-1:0] INT_MAX = {IntW{1'b1}};

  typedef struct packed {
    logic [RunW-1:0] min_rising_run;
    logic [IntW-1:0] nominal_interval;
    logic [IntW-1:0] interval_tolerance;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0] peak_index;
    logic [IntW-1:0] interval_length;
    logic            first_peak;
    logic            too_far;
  } peak_result_t;

endpackage

### sv/timing_pulse_peak_detector_core.sv
// Top level of the timing pulse peak detector: input register, tracker, result register.
// Depends on tppd_pkg and tppd_tracker.
//
// Usage:
//   Samples of the sync channel enter on sample_valid/sample_stall with sync_sample;
//   a request is taken at an edge with sample_valid high and sample_stall low.
//   Each sample advances a 32-bit position counter. When a qualified pulse peak
//   is found, one result leaves on peak_valid/peak_stall carrying peak_index,
//   interval_length, first_peak and too_far; most samples give no result.
//   The sample that ends the peak search passes the input register and the tracker
//   update; its result is then held in the result register until it is taken.
//   Throughput: one sample per cycle while sample_stall is low; the result
//   register lets the next sample in while a result waits.
//   If peak_stall holds a waiting result and a further sample in the input
//   register would produce another one, that sample holds and sample_stall rises.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Write only while the block is idle.
//   Reset (rst, synchronous): position, candidate and peak history clear, the
//   registers return to 10 / 4800 / 10, and both channels go empty.
module timing_pulse_peak_detector_core import tppd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_stall,
  input  logic signed [SampW-1:0] sync_sample,
  output logic                    peak_valid,
  input  logic                    peak_stall,
  output logic [PosW-1:0]         peak_index,
  output logic [IntW-1:0]         interval_length,
  output logic                    first_peak,
  output logic                    too_far,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [RegIdxW-1:0]      cfg_index,
  input  logic [31:0]             cfg_data
);

  cfg_t                    cfg;
  logic                    in_full;
  logic signed [SampW-1:0] in_sample;
  logic                    emit;
  peak_result_t            result;
  peak_result_t            held;
  logic                    out_free;
  logic                    advance;
  logic                    take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_rising_run     <= RST_MIN_RISING_RUN;
      cfg.nominal_interval   <= RST_NOMINAL_INTERVAL;
      cfg.interval_tolerance <= RST_INTERVAL_TOLERANCE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_RISING_RUN:     cfg.min_rising_run     <= cfg_data[RunW-1:0];
        REG_NOMINAL_INTERVAL:   cfg.nominal_interval   <= cfg_data[IntW-1:0];
        REG_INTERVAL_TOLERANCE: cfg.interval_tolerance <= cfg_data[IntW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free     = !peak_valid || !peak_stall;
  assign advance      = in_full && (!emit || out_free);
  assign sample_stall = in_full && !advance;
  assign take         = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_sample <= sync_sample;
    end
  end

  tppd_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .sample  (in_sample),
    .cfg     (cfg),
    .emit    (emit),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_valid <= 1'b0;
    end else if (advance && emit) begin
      peak_valid <= 1'b1;
    end else if (!peak_stall) begin
      peak_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      held <= result;
    end
  end

  assign peak_index      = held.peak_index;
  assign interval_length = held.interval_length;
  assign first_peak      = held.first_peak;
  assign too_far         = held.too_far;

endmodule

### sv/tppd_tracker.sv
// Pulse qualification state and its single-cycle update for one sample.
// Depends on tppd_pkg for the configuration and result structs.
module tppd_tracker import tppd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic signed [SampW-1:0] sample,
  input  cfg_t                    cfg,
  output logic                    emit,
  output peak_result_t            result
);

  logic [PosW-1:0]         sample_position;
  logic                    candidate_valid;
  logic [PosW-1:0]         candidate_position;
  logic signed [SampW-1:0] running_max;
  logic [RunW-1:0]         rise_run;
  logic                    peak_search;
  logic [PosW-1:0]         last_peak_position;
  logic                    have_last_peak;

  logic                    candidate_valid_next;
  logic [PosW-1:0]         candidate_position_next;
  logic signed [SampW-1:0] running_max_next;
  logic [RunW-1:0]         rise_run_next;
  logic                    peak_search_next;
  logic [RunW-1:0]         run_inc;
  logic                    above;
  logic                    below;
  logic                    positive;
  logic [PosW-1:0]         diff;
  logic [IntW:0]           limit;

  assign above    = sample > running_max;
  assign below    = sample < running_max;
  assign positive = sample > $signed({SampW{1'b0}});
  assign run_inc  = (rise_run == RUN_MAX) ? rise_run : rise_run + 1'b1;

  assign diff  = candidate_position - last_peak_position;
  assign limit = {1'b0, cfg.nominal_interval} + {1'b0, cfg.interval_tolerance};

  assign emit = peak_search && below;

  always_comb begin
    result.peak_index = candidate_position;
    if (have_last_peak) begin
      result.interval_length = (diff[PosW-1:IntW] != '0) ? INT_MAX : diff[IntW-1:0];
      result.first_peak      = 1'b0;
      result.too_far         = diff > {{(PosW-IntW-1){1'b0}}, limit};
    end else begin
      result.interval_length = '0;
      result.first_peak      = 1'b1;
      result.too_far         = 1'b0;
    end
  end

  always_comb begin
    candidate_valid_next    = candidate_valid;
    candidate_position_next = candidate_position;
    running_max_next        = running_max;
    rise_run_next           = rise_run;
    peak_search_next        = peak_search;
    if (peak_search) begin
      if (above) begin
        running_max_next        = sample;
        candidate_position_next = sample_position;
      end else if (below) begin
        // End of search: restart from the sample that ended it
        peak_search_next = 1'b0;
        rise_run_next    = '0;
        if (positive) begin
          candidate_valid_next    = 1'b1;
          candidate_position_next = sample_position;
          running_max_next        = sample;
        end else begin
          candidate_valid_next = 1'b0;
          running_max_next     = '0;
        end
      end
    end else if (!positive) begin
      candidate_valid_next = 1'b0;
      rise_run_next        = '0;
    end else if (!candidate_valid) begin
      candidate_valid_next    = 1'b1;
      candidate_position_next = sample_position;
      rise_run_next           = '0;
      running_max_next        = sample;
    end else if (above) begin
      running_max_next = sample;
      rise_run_next    = run_inc;
      if (run_inc >= cfg.min_rising_run) begin
        peak_search_next = 1'b1;
      end
    end else if (below) begin
      // Falling sample: move the candidate start here
      running_max_next        = sample;
      candidate_position_next = sample_position;
      rise_run_next           = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_position    <= '0;
      candidate_valid    <= 1'b0;
      candidate_position <= '0;
      running_max        <= '0;
      rise_run           <= '0;
      peak_search        <= 1'b0;
      last_peak_position <= '0;
      have_last_peak     <= 1'b0;
    end else if (advance) begin
      sample_position    <= sample_position + 1'b1;
      candidate_valid    <= candidate_valid_next;
      candidate_position <= candidate_position_next;
      running_max        <= running_max_next;
      rise_run           <= rise_run_next;
      peak_search        <= peak_search_next;
      if (emit) begin
        last_peak_position <= candidate_position;
        have_last_peak     <= 1'b1;
      end
    end
  end

endmodule

### tb/sv/timing_pulse_peak_detector_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for timing_pulse_peak_detector_core: directed pulse shapes, then
// random pulse trains under three idling mixes. Depends on tppd_pkg and the core RTL.
module timing_pulse_peak_detector_core_test;
  import tppd_pkg::*;

  localparam logic [RegIdxW-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned MAX_REPORTS = 20;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    sample_valid = 1'b0;
  logic                    sample_stall;
  logic signed [SampW-1:0] sync_sample = '0;
  logic                    peak_valid;
  logic                    peak_stall = 1'b0;
  logic [PosW-1:0]         peak_index;
  logic [IntW-1:0]         interval_length;
  logic                    first_peak;
  logic                    too_far;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [RegIdxW-1:0]      cfg_index = '0;
  logic [31:0]             cfg_data = '0;

  timing_pulse_peak_detector_core DUT (
    .clk             (clk),
    .rst             (rst),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .sync_sample     (sync_sample),
    .peak_valid      (peak_valid),
    .peak_stall      (peak_stall),
    .peak_index      (peak_index),
    .interval_length (interval_length),
    .first_peak      (first_peak),
    .too_far         (too_far),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Detector shadow state
  cfg_t                    det_cfg = '{min_rising_run: RST_MIN_RISING_RUN,
                                       nominal_interval: RST_NOMINAL_INTERVAL,
                                       interval_tolerance: RST_INTERVAL_TOLERANCE};
  logic [PosW-1:0]         pos_cnt = '0;
  logic                    cand_ok = 1'b0;
  logic [PosW-1:0]         cand_pos = '0;
  logic signed [SampW-1:0] run_max = '0;
  logic [RunW-1:0]         rise_cnt = '0;
  logic                    searching = 1'b0;
  logic [PosW-1:0]         last_peak = '0;
  logic                    have_peak = 1'b0;

  peak_result_t pending_peaks[$];

  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;
  int unsigned samples_sent = 0;
  int unsigned peaks_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("timing_pulse_peak_detector_core: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    peak_stall <= (recv_pct != 0) && ($urandom_range(0, 99) < recv_pct);
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
  endtask

  always @(posedge clk) begin
    peak_result_t want;
    if (!rst && peak_valid && !peak_stall) begin
      if (pending_peaks.size() == 0) begin
        report_mismatch($sformatf("unexpected peak at index %0d", peak_index));
      end else begin
        want = pending_peaks.pop_front();
        peaks_checked++;
        if (peak_index !== want.peak_index)
          report_mismatch($sformatf("peak_index got %0d want %0d",
                                    peak_index, want.peak_index));
        if (interval_length !== want.interval_length)
          report_mismatch($sformatf("interval_length got %0d want %0d (peak %0d)",
                                    interval_length, want.interval_length, want.peak_index));
        if (first_peak !== want.first_peak)
          report_mismatch($sformatf("first_peak got %b want %b (peak %0d)",
                                    first_peak, want.first_peak, want.peak_index));
        if (too_far !== want.too_far)
          report_mismatch($sformatf("too_far got %b want %b (peak %0d)",
                                    too_far, want.too_far, want.peak_index));
      end
    end
  end

  // Advance the shadow detector by one sample; queue a peak when search ends
  task automatic predict_peak(logic signed [SampW-1:0] s);
    peak_result_t    r;
    logic [PosW-1:0] here;
    logic [PosW-1:0] diff;
    logic [IntW:0]   limit;
    here = pos_cnt;
    pos_cnt = pos_cnt + 1;
    if (searching) begin
      if (s > run_max) begin
        run_max = s;
        cand_pos = here;
      end else if (s < run_max) begin
        diff = cand_pos - last_peak;
        limit = {1'b0, det_cfg.nominal_interval} + {1'b0, det_cfg.interval_tolerance};
        r.peak_index = cand_pos;
        r.first_peak = !have_peak;
        if (!have_peak) r.interval_length = '0;
        else r.interval_length = (diff > PosW'(INT_MAX)) ? INT_MAX : diff[IntW-1:0];
        r.too_far = have_peak && (diff > PosW'(limit));
        pending_peaks.insert(pending_peaks.size(), r);
        last_peak = cand_pos;
        have_peak = 1'b1;
        searching = 1'b0;
        rise_cnt = '0;
        if (s > 0) begin
          cand_ok = 1'b1;
          cand_pos = here;
          run_max = s;
        end else begin
          cand_ok = 1'b0;
          run_max = '0;
        end
      end
    end else if (s <= 0) begin
      cand_ok = 1'b0;
      rise_cnt = '0;
    end else if (!cand_ok) begin
      cand_ok = 1'b1;
      cand_pos = here;
      rise_cnt = '0;
      run_max = s;
    end else if (s > run_max) begin
      run_max = s;
      if (rise_cnt != RUN_MAX) rise_cnt = rise_cnt + 1'b1;
      if (rise_cnt >= det_cfg.min_rising_run) searching = 1'b1;
    end else if (s < run_max) begin
      run_max = s;
      cand_pos = here;
      rise_cnt = '0;
    end
  endtask

  task automatic send_sample(logic signed [SampW-1:0] s);
    // idle cycle by cycle at the chosen rate
    while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sync_sample  <= s;
    do @(posedge clk); while (sample_stall);
    samples_sent++;
    predict_peak(s);
  endtask

  // Drop the request, let every queued peak arrive, then let the pipeline settle
  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [31:0] value);
    logic [31:0] data;
    // junk above the register width must be dropped by the block
    data = (value & 32'h0000_FFFF) | ($urandom() & 32'hFFFF_0000);
    if (idx == REG_MIN_RISING_RUN) data[15:8] = 8'($urandom());
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_MIN_RISING_RUN:     det_cfg.min_rising_run = data[RunW-1:0];
      REG_NOMINAL_INTERVAL:   det_cfg.nominal_interval = data[IntW-1:0];
      REG_INTERVAL_TOLERANCE: det_cfg.interval_tolerance = data[IntW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(int unsigned run, int unsigned nominal, int unsigned tol);
    wait_idle();
    write_reg(REG_MIN_RISING_RUN, run);
    write_reg(REG_NOMINAL_INTERVAL, nominal);
    write_reg(REG_INTERVAL_TOLERANCE, tol);
  endtask

  task automatic send_noise(int unsigned count, bit non_positive);
    int unsigned i;
    int          v;
    for (i = 0; i < count; i++) begin
      if (non_positive) v = -int'($urandom_range(0, 32768));
      else v = int'($urandom());
      send_sample(SampW'(v));
    end
  endtask

  // One pulse: open, rises (with equal repeats, optionally broken), more growth in search, then a fall
  task automatic send_pulse(int unsigned rises, int unsigned extra, bit spoil);
    int          lvl;
    int          step_max;
    int unsigned i;
    lvl = $urandom_range(1, 3000);
    send_sample(SampW'(lvl));
    step_max = 29000 / int'(rises + extra + 1);
    if (step_max < 1) step_max = 1;
    for (i = 0; i < rises + extra; i++) begin
      if ($urandom_range(0, 9) == 0) send_sample(SampW'(lvl));
      lvl = lvl + $urandom_range(1, step_max);
      send_sample(SampW'(lvl));
      if (spoil && i == rises / 2) begin
        // broken run: a dip or a drop to zero or below
        if ($urandom_range(0, 1)) lvl = lvl - $urandom_range(1, lvl);
        else lvl = -int'($urandom_range(0, 32768));
        send_sample(SampW'(lvl));
        if (lvl < 1) lvl = 1;
      end
    end
    send_sample(SampW'(lvl - int'($urandom_range(1, lvl + 32768))));
  endtask

  task automatic set_idling(int unsigned s_pct, int unsigned r_pct);
    send_pct = s_pct;
    recv_pct = r_pct;
  endtask

  task automatic test_reset_defaults();
    send_sample('0);
    send_pulse(RST_MIN_RISING_RUN, 0, 1'b0);
  endtask

  task automatic test_directed_shapes();
    set_config(0, 3, 0);
    send_sample('0);
    send_sample(16'sd1);
    send_sample(16'sd2);
    send_sample(16'sd2);       // equal in search: nothing
    send_sample(16'sd1);       // flat peak: reported at the opening position
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(16'sd32767);   // equal with a candidate open: nothing
    send_sample(16'sd100);     // falling: candidate moves here
    send_sample(16'sd200);
    send_sample(16'sd32767);
    send_sample(16'sd32767);
    send_sample(-16'sd1);
  endtask

  task automatic test_register_writes();
    set_config(1, 1, 0);
    write_reg(REG_UNUSED, $urandom());
    send_pulse(1, 0, 1'b0);
    send_pulse(1, 1, 1'b0);
    set_config(2, INT_MAX, INT_MAX);
    send_pulse(2, 2, 1'b0);
    send_noise(3, 1'b0);
    send_pulse(2, 0, 1'b0);
  endtask

  task automatic test_longest_run();
    set_config(RUN_MAX, 300, 0);
    send_sample('0);
    send_pulse(RUN_MAX, 1, 1'b0);
  endtask

  task automatic test_random_traffic(int unsigned s_pct, int unsigned r_pct,
                                     int unsigned budget);
    int unsigned start;
    int unsigned next_cfg;
    int unsigned run;
    wait_idle();
    set_idling(s_pct, r_pct);
    start = samples_sent;
    next_cfg = samples_sent;
    run = 1;
    while (samples_sent - start < budget) begin
      if (samples_sent >= next_cfg) begin
        run = $urandom_range(0, 5);
        set_config(run, ($urandom_range(0, 9) == 0) ? INT_MAX : $urandom_range(1, 30),
                   ($urandom_range(0, 9) == 0) ? INT_MAX : $urandom_range(0, 8));
        next_cfg = samples_sent + $urandom_range(40, 80);
      end
      if ($urandom_range(0, 99) < 4) wait_idle();
      if ($urandom_range(0, 99) < 80)
        send_pulse((run == 0) ? 1 : run, $urandom_range(0, 3), $urandom_range(0, 99) < 15);
      else
        send_noise($urandom_range(1, 6), $urandom_range(0, 1));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed_shapes();
    test_register_writes();
    test_longest_run();
    test_random_traffic(26, 66, 75);
    test_random_traffic(66, 26, 75);
    test_random_traffic(0, 0, 75);

    wait_idle();
    set_idling(0, 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d samples and checked %0d peaks over %0d register writes,",
             samples_sent, peaks_checked, reg_writes);
    $display("covering flat and moving candidates, broken runs and the longest rising run.");
    if (mismatches == 0) begin
      $display("timing_pulse_peak_detector_core: match");
    end else begin
      $display("timing_pulse_peak_detector_core: mismatch");
    end
    $finish;
  end

endmodule
